[hw/rtl/kmp_pkg.sv]
// shared constants and types for the kmp first-match search block
package kmp_pkg;

    // default sizing, handed to the top level parameters
    localparam int KMP_MAX_PATTERN_DEF = 8;
    localparam int KMP_INDEX_BITS_DEF  = 16;

    // fixed field widths
    localparam int CHAR_W    = 8;
    localparam int PAT_CFG_W = 64;
    localparam int PLEN_W    = 4;
    localparam int OFFSET_W  = 16;
    localparam int POS_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // number of pattern bytes the pattern register can carry
    localparam int PAT_CFG_BYTES = PAT_CFG_W / CHAR_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 2'd2;

    // control handed from the sequencer to every cell of the chain
    typedef struct packed {
        logic load;   // first byte of a text: take the pattern byte from config
        logic step;   // byte is searched: advance the partial-match bit
        logic clear;  // last byte of a text: drop all partial matches
    } cell_ctl_t;

endpackage

[hw/rtl/kmp_cell.sv]
// one matcher cell: holds a pattern byte and the partial-match bit for its prefix
module kmp_cell
    import kmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctl_t         ctl,
    input  logic [CHAR_W-1:0] cfg_byte,
    input  logic [CHAR_W-1:0] text_char,
    input  logic              prev_hit,
    output logic              hit_now,
    output logic              hit
);

    logic [CHAR_W-1:0] byte_reg;
    logic [CHAR_W-1:0] byte_use;
    logic              hit_reg;

    // a new text sees the configured byte already on its first byte
    assign byte_use = ctl.load ? cfg_byte : byte_reg;
    // prefix up to this cell matches when the left neighbor matched one byte earlier
    assign hit_now  = prev_hit & (byte_use == text_char);
    assign hit      = hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            byte_reg <= cfg_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.clear) begin
            hit_reg <= 1'b0;
        end else if (ctl.step) begin
            hit_reg <= hit_now;
        end
    end

endmodule

[hw/rtl/kmp_first_match_search.sv]
// top level of the kmp first-match search block: config, cell chain, sequencer, output register
//
// usage
//   configure pattern_bytes (index 0), pattern_length (index 1) and start_offset (index 2)
//   through cfg_wr_en / cfg_index / cfg_wdata while no text is in flight
//   stream the text one byte per transaction on the s_ channel, s_tlast on the final byte
//   at most one result transaction per text on the m_ channel:
//     m_tuser = 1 and m_tdata = start index of the first match, or
//     m_tuser = 0 and m_tdata = 0 when the final byte passes without a match
//   bytes after the first match give no result; the final byte then only resets the text
// latency and throughput
//   one byte per cycle unless a result waits stalled on m_; a result shows on m_ in the cycle
//   after the byte that caused it; each byte is matched combinationally by a row of MAX_PATTERN
//   cells, one per pattern byte, each handing its partial-match bit to its right neighbor
// reset
//   aresetn (synchronous, active low) clears the text state, the cells' match bits and
//   the output valid; registers return to pattern 0, length 1, offset 0
// stall
//   while a result waits in the output register and m_tready is low, s_tready drops;
//   nothing is lost or repeated
module kmp_first_match_search
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = KMP_MAX_PATTERN_DEF,
    parameter int INDEX_BITS  = KMP_INDEX_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // text input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] text_char
    input  logic                  s_tlast,   // text_last
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [POS_W-1:0]      m_tdata,   // [15:0] match_position
    output logic                  m_tuser    // [0] found
);

    localparam int CELL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW     = INDEX_BITS + 1;
    localparam int CMP_W  = (INDEX_BITS > OFFSET_W) ? INDEX_BITS : OFFSET_W;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

    // configuration registers
    logic [PAT_CFG_W-1:0] pattern_bytes_reg;
    logic [PLEN_W-1:0]    pattern_length_reg;
    logic [OFFSET_W-1:0]  start_offset_reg;

    // per-text state
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic [CELL_W-1:0]     sel_reg;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [POS_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  s_acc;
    logic                  first_byte;
    logic [CELL_W-1:0]     sel_cfg;
    logic [CELL_W-1:0]     sel_use;
    cell_ctl_t             ctl;
    logic [MAX_PATTERN-1:0] hit_now;
    logic [MAX_PATTERN-1:0] hit;
    logic                  match;
    logic [PW-1:0]         idx_p1;
    logic [PW-1:0]         len_use;
    logic [PW-1:0]         pos_full;

    // config writes, unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= PLEN_W'(1);
            start_offset_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_wdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[PLEN_W-1:0];
                REG_START_OFFSET:   start_offset_reg   <= cfg_wdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: output register frees up when taken
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_acc      = s_tvalid && s_tready;
    assign first_byte = (idx_reg == '0) && !done_reg;

    // last cell of the pattern: zero length acts as one, long lengths saturate
    always_comb begin
        if (pattern_length_reg == '0) begin
            sel_cfg = '0;
        end else if (32'(pattern_length_reg) > MAX_PATTERN) begin
            sel_cfg = CELL_W'(MAX_PATTERN - 1);
        end else begin
            sel_cfg = CELL_W'(pattern_length_reg - PLEN_W'(1));
        end
    end

    assign sel_use = first_byte ? sel_cfg : sel_reg;

    // cell control for this transaction
    assign ctl.load  = s_acc && first_byte;
    assign ctl.step  = s_acc && !done_reg &&
                       (CMP_W'(idx_reg) >= CMP_W'(start_offset_reg));
    assign ctl.clear = s_acc && s_tlast;

    // chain of cells, cell k tracks the prefix of length k+1
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [CHAR_W-1:0] cfg_byte;
        logic              prev_hit;

        if (k < PAT_CFG_BYTES) begin : g_cfg
            assign cfg_byte = pattern_bytes_reg[CHAR_W*k +: CHAR_W];
        end else begin : g_zero
            // bytes past the pattern register read as zero
            assign cfg_byte = '0;
        end

        if (k == 0) begin : g_head
            assign prev_hit = 1'b1;
        end else begin : g_link
            assign prev_hit = hit[k-1];
        end

        kmp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .cfg_byte  (cfg_byte),
            .text_char (s_tdata),
            .prev_hit  (prev_hit),
            .hit_now   (hit_now[k]),
            .hit       (hit[k])
        );
    end

    // full match when the last pattern cell lights up on a searched byte
    assign match = ctl.step && hit_now[sel_use];

    // match start = index + 1 - length
    assign idx_p1   = PW'(idx_reg) + PW'(1);
    assign len_use  = PW'(sel_use) + PW'(1);
    assign pos_full = (idx_p1 >= len_use) ? (idx_p1 - len_use) : '0;

    // text state sequencing
    always_comb begin
        idx_next  = idx_reg;
        done_next = done_reg;
        if (s_acc) begin
            if (s_tlast) begin
                idx_next  = '0;
                done_next = 1'b0;
            end else begin
                if (idx_reg != INDEX_MAX) begin
                    idx_next = idx_reg + INDEX_BITS'(1);
                end
                if (match) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            sel_reg <= sel_cfg;
        end
    end

    // output register: found result, or not-found on a final byte without match
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (match) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = POS_W'(pos_full);
            m_tuser_next  = 1'b1;
        end else if (s_acc && s_tlast && !done_reg) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tuser_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a final byte always leaves a fresh text behind
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> (idx_reg == '0) && !done_reg && (hit == '0))
        else $error("text state not cleared after final byte");

    // a match in mid-text ends the search
    a_match_done: assert property (@(posedge aclk) disable iff (!aresetn)
        match && !s_tlast |=> done_reg)
        else $error("search not marked done after match");

    // no cell advances once the search is over
    a_done_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !ctl.step)
        else $error("cell stepped after search finished");

    // input only stalls behind an occupied output register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg && !m_tready)
        else $error("input stalled without a pending result");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg)
                                      && $stable(m_tuser_reg))
        else $error("pending result overwritten");

endmodule

[sim/kmp_first_match_search_tb.sv]
// self-checking testbench for kmp_first_match_search: directed table, random texts
`timescale 1ns / 100ps

module kmp_first_match_search_tb;
    import kmp_pkg::*;

    localparam int PAT_MAX = KMP_MAX_PATTERN_DEF;
    localparam logic [KMP_INDEX_BITS_DEF-1:0] INDEX_TOP = '1;
    // index 3 is not decoded by the block, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;

    // one search result as it leaves the block
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } search_result_t;

    // one row of the directed table: either a register write or a text byte
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [CHAR_W-1:0]     ch;
        logic                  last;
        logic                  typed;   // result given in the row, not by the predictor
        search_result_t        want;
    } drill_row_t;

    // dut ports, all driven inputs known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata   = '0;   // [7:0] text_char
    logic                  s_tlast   = 1'b0; // text_last
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [POS_W-1:0]      m_tdata;          // [15:0] match_position
    logic                  m_tuser;          // [0] found

    // register shadows, as last written
    logic [CFG_DATA_W-1:0] reg_pattern = '0;
    logic [PLEN_W-1:0]     reg_length  = 4'd1;
    logic [OFFSET_W-1:0]   reg_offset  = '0;

    // search state of the text in flight
    logic [7:0]                    pat_byte [PAT_MAX];
    int                            fail_link [PAT_MAX];
    int                            pat_len     = 1;
    int                            cur_matched = 0;
    logic [KMP_INDEX_BITS_DEF-1:0] cur_index   = '0;
    bit                            cur_done    = 1'b0;

    // results still owed by the block, oldest first
    search_result_t results_due [$];

    int mismatches = 0;
    int items_sent = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    bit narrow_alpha = 1'b1;

    // long receiver hold-off, requested by toggling, counted by the receiver
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;

    int phase_idle  [4] = '{0, 81, 0, 25};
    int phase_stall [4] = '{0, 0, 81, 25};

    // directed rows: reset defaults, long and clamped patterns, border fallback,
    // dropped register index, zero length, start offset and offset past the text
    drill_row_t drill_table [28] = '{
        // reset pattern is a single zero byte
        '{1'b0, '0, '0, 8'h00, 1'b1, 1'b1, '{1'b1, 16'd0}},
        '{1'b0, '0, '0, 8'hFF, 1'b1, 1'b1, '{1'b0, 16'd0}},
        // all-ones pattern, length 15 clamps to eight bytes
        '{1'b1, REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
        '{1'b1, REG_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'hFF, 1'b0, 1'b1, '{1'b1, 16'd0}},
        // byte after the match: only clears
        '{1'b0, '0, '0, 8'h00, 1'b1, 1'b0, '0},
        // "aab" against "aaab": fall back along the border, match on last byte
        '{1'b1, REG_PATTERN_BYTES, 64'h0062_6161, 8'h00, 1'b0, 1'b0, '0},
        '{1'b1, REG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, '0},
        '{1'b1, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_B, 1'b1, 1'b1, '{1'b1, 16'd1}},
        // length zero acts as one, first byte skipped by the start offset
        '{1'b1, REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '0},
        '{1'b1, REG_START_OFFSET, 64'd2, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'h78, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b1, 1'b1, '{1'b1, 16'd2}},
        // start offset never reached
        '{1'b1, REG_START_OFFSET, 64'hFFFF, 8'h00, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, CH_A, 1'b1, 1'b1, '{1'b0, 16'd0}}
    };

    kmp_first_match_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // advance the search by one accepted text byte
    function automatic void search_step(input logic [7:0] ch, input logic last,
                                        output bit has, output search_result_t res);
        int k;
        int b;
        int j;
        int len;
        has = 1'b0;
        res = '0;
        // first byte of a text latches the pattern and builds the borders
        if (cur_index == 0 && !cur_done) begin
            len = reg_length;
            if (len == 0) len = 1;
            if (len > PAT_MAX) len = PAT_MAX;
            pat_len = len;
            for (k = 0; k < PAT_MAX; k++) pat_byte[k] = reg_pattern[8*k +: 8];
            fail_link[0] = 0;
            b = 0;
            for (k = 1; k < len; k++) begin
                while (b > 0 && pat_byte[k] != pat_byte[b]) b = fail_link[b-1];
                if (pat_byte[k] == pat_byte[b]) b++;
                fail_link[k] = b;
            end
        end
        if (!cur_done && cur_index >= reg_offset) begin
            j = cur_matched;
            if (j >= pat_len) j = 0;
            while (j > 0 && pat_byte[j] != ch) j = fail_link[j-1];
            if (pat_byte[j] == ch) j++;
            if (j >= pat_len) begin
                has = 1'b1;
                res.found = 1'b1;
                // past saturation the start is taken from the clamped index
                res.pos = (int'(cur_index) + 1 >= pat_len) ?
                          POS_W'(int'(cur_index) + 1 - pat_len) : '0;
                cur_done = 1'b1;
                j = 0;
            end
            cur_matched = j;
        end
        if (cur_index != INDEX_TOP) cur_index++;
        if (last) begin
            if (!has && !cur_done) begin
                has = 1'b1;
                res = '0;
            end
            cur_matched = 0;
            cur_index = '0;
            cur_done = 1'b0;
        end
    endfunction

    function automatic logic [7:0] pick_char();
        if (narrow_alpha) return CH_A + 8'($urandom_range(1));
        return 8'($urandom_range(255));
    endfunction

    // register write, enable is dropped by whatever comes next
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_PATTERN_BYTES:  reg_pattern = val;
            REG_PATTERN_LENGTH: reg_length = val[PLEN_W-1:0];
            REG_START_OFFSET:   reg_offset = val[OFFSET_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // stop offering, wait for every owed result and let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // offer one text byte, predict on acceptance
    task automatic send_byte(input logic [7:0] ch, input logic last,
                             input bit typed, input search_result_t typed_res);
        bit has;
        search_result_t res;
        cfg_wr_en <= 1'b0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        search_step(ch, last, has, res);
        if (typed) results_due.push_back(typed_res);
        else if (has) results_due.push_back(res);
        items_sent++;
    endtask

    // new pattern, length and offset, biased toward a two-letter alphabet
    task automatic random_setting();
        logic [CFG_DATA_W-1:0] pat;
        logic [CFG_DATA_W-1:0] len_word;
        logic [CFG_DATA_W-1:0] off_word;
        int k;
        int roll;
        narrow_alpha = ($urandom_range(99) < 70);
        for (k = 0; k < PAT_CFG_BYTES; k++) pat[8*k +: 8] = pick_char();
        len_word = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 80) len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(8, 1));
        else if (roll < 90) len_word[PLEN_W-1:0] = '0;
        else len_word[PLEN_W-1:0] = PLEN_W'($urandom_range(15, 9));
        off_word = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 65) off_word[OFFSET_W-1:0] = '0;
        else if (roll < 90) off_word[OFFSET_W-1:0] = OFFSET_W'($urandom_range(6, 1));
        wait_idle();
        cfg_write(REG_PATTERN_BYTES, pat);
        cfg_write(REG_PATTERN_LENGTH, len_word);
        cfg_write(REG_START_OFFSET, off_word);
    endtask

    // one text: mostly alphabet text, often with the pattern planted, some pure noise
    task automatic random_text();
        logic [7:0] text_q [$];
        int tl;
        int len;
        int p;
        int k;
        bit shaped;
        shaped = ($urandom_range(99) < 75);
        tl = $urandom_range(24, 1);
        for (k = 0; k < tl; k++)
            text_q.push_back(shaped ? pick_char() : 8'($urandom_range(255)));
        len = (reg_length == 0) ? 1 : (reg_length > PAT_MAX) ? PAT_MAX : reg_length;
        if (shaped && tl >= len && $urandom_range(1) == 1) begin
            p = $urandom_range(tl - len);
            for (k = 0; k < len; k++) text_q[p+k] = reg_pattern[8*k +: 8];
        end
        for (k = 0; k < tl; k++) send_byte(text_q[k], k == tl - 1, 1'b0, '0);
    endtask

    // receiver: random stalls per phase, or a long counted hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= 300;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare every result transaction against the oldest owed result
    always @(posedge aclk) begin : result_check
        search_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found %0b position %0d", m_tuser, m_tdata);
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.found || m_tdata !== want.pos) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected found %0b position %0d,",
                                  " got found %0b position %0d"},
                                 want.found, want.pos, m_tuser, m_tdata);
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        int ph;
        int goal;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, registers only touched with the block drained
        for (i = 0; i < 28; i++) begin
            if (drill_table[i].is_cfg) begin
                wait_idle();
                cfg_write(drill_table[i].idx, drill_table[i].val);
            end else begin
                send_byte(drill_table[i].ch, drill_table[i].last,
                          drill_table[i].typed, drill_table[i].want);
            end
        end

        // random texts across the idling phases
        for (ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            random_setting();
            // back-to-back bytes against a held-off receiver fill the block
            if (ph == 0) hold_req <= ~hold_req;
            goal = items_sent + 130;
            while (items_sent < goal) begin
                random_text();
                if ($urandom_range(99) < 30) random_setting();
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("kmp_first_match_search test passed");
        end else begin
            $display("kmp_first_match_search test failed");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("kmp_first_match_search test failed");
        $finish;
    end

endmodule

[kmp_first_match_search.f]
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_cell.sv
hw/rtl/kmp_first_match_search.sv
sim/kmp_first_match_search_tb.sv
